// ===== hdl/plcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_pkg
// Types and fixed constants shared by the point light cell shader files.
// ----------------------------------------------------------------------------
package plcs_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS = 8'd3;

  localparam logic CMD_WRITE_LIGHT = 1'b0;
  localparam logic CMD_SHADE_CELL  = 1'b1;

  // Q1.16 fractions, distance root with 12 fraction bits
  localparam int FRAC_BITS = 16;
  localparam int DIST_FRAC = 12;
  localparam logic [FRAC_BITS:0] ONE = 17'h10000;

  localparam int RAD_W      = 60;
  localparam int ROOT_W     = 30;
  localparam int SQRT_STEPS = 30;
  localparam int DIV_NUM_W  = 33;
  localparam int DIV_DEN_W  = 32;
  localparam int QUOT_W     = 17;

  // glow sum at which sum / (255 * 2^16 / 128) reaches 255
  localparam int GLOW_SAT = 33292800;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         light_slot;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic [15:0]        light_radius;
    logic [7:0]         light_red;
    logic [7:0]         light_green;
    logic [7:0]         light_blue;
    logic               light_on;
    logic [9:0]         cell_col;
    logic [9:0]         cell_row;
  } in_word_t;

  typedef struct packed {
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic [7:0] shadow_alpha;
    logic [7:0] glow_red;
    logic [7:0] glow_green;
    logic [7:0] glow_blue;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [15:0]        reach;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } light_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTER,
    ST_READ,
    ST_DIST,
    ST_SQUARE,
    ST_TEST,
    ST_SQRT,
    ST_SHDIV,
    ST_GLDIV,
    ST_UMUL,
    ST_ACC,
    ST_SATCHK,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/plcs_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module plcs_isqrt
  import plcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [31:0]       rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [33:0]       rs, trial;
  logic              fits;

  always_comb begin
    rs    = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    fits  = rs >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(SQRT_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= 32'(rs - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rs[31:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hdl/plcs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_div
// Restoring divider for (num << 16) / den with a 17-bit quotient, one bit
// per cycle. The quotient must stay below 2^17.
// ----------------------------------------------------------------------------
module plcs_div
  import plcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [QUOT_W-1:0]    quot_o
);

  logic                 busy_q, done_q;
  logic [4:0]           cnt_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic                 lsb_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [DIV_DEN_W:0]   rs;
  logic                 fits;

  always_comb begin
    // first step shifts in the numerator's low bit, the rest shift in zeros
    rs   = {rem_q, (cnt_q == '0) ? lsb_q : 1'b0};
    fits = rs >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(QUOT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[DIV_NUM_W-1:1];
      lsb_q  <= num_i[0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q  <= DIV_DEN_W'(rs - {1'b0, den_q});
        quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rs[DIV_DEN_W-1:0];
        quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/point_light_cell_shader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_light_cell_shader_unit
// Shades grid cells against a table of point lights.
// ----------------------------------------------------------------------------
// Input words (valid/ready) either write one light table entry (cmd 0) or
// shade one cell (cmd 1). A light write completes in the accept cycle and
// returns nothing. A shade word returns one output word with the cell index,
// the shadow alpha and the saturated RGB glow.
// The table sits in one synchronous memory read once per light. Shading walks
// all MAX_LIGHTS entries in turn: a disabled light is skipped after its read,
// a light out of range after the distance test, a light in shadow range also
// takes a square root of 30 steps and a 17-step divide, and one in glow range
// a second 17-step divide and the glow accumulation. Around the walk come the
// idle accept, the cell center, the glow scaling and the result load.
// One shade word is in work at a time; in_ready_o is high only while the
// engine is idle. The result sits in an output register: the engine may take
// the next word while it waits, and stalls before writing a new result over
// it. Reset clears the enable bits of all lights and loads the register
// defaults; the positions, radii and colors hold garbage until written.
// The configuration port is always ready; the user must write it only while
// idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module point_light_cell_shader_unit
  import plcs_pkg::*;
#(
  parameter int MAX_LIGHTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IdxW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int SumW = 25 + IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_LIGHTS - 1);

  // configuration
  logic signed [15:0] view_left_q, view_top_q;
  logic [10:0]        cell_size_q;
  logic [16:0]        min_bright_q;

  // control
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [MAX_LIGHTS-1:0] en_q;
  logic            out_valid_q;
  out_word_t       out_word_q;

  // light table
  light_t mem [MAX_LIGHTS];
  light_t rd_q;

  // datapath
  logic [9:0]         col_q, row_q;
  logic signed [24:0] cx2_q, cy2_q;
  logic [23:0]        dx_q, dy_q;
  logic [48:0]        d2_q;
  logic [31:0]        r2_q;
  logic               glow_q;
  logic [16:0]        bright_q, u_q, u2_q;
  logic [SumW-1:0]    sum_q  [3];
  logic [7:0]         sq_q   [3];
  logic               sat_q  [3];

  logic in_acc, wr_light, adv, last;
  logic sqrt_start, sqrt_done, div_start, div_done, div_glow, load_out;
  logic [ROOT_W-1:0]    root;
  logic [QUOT_W-1:0]    quot;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [7:0]           slot_ext;
  logic [53:0]          d2x25, r2x144;
  logic                 in_shadow;
  logic signed [24:0]   vl2, vt2, pcx, pcy, cs_e, ddx, ddy;
  logic [16:0]          cand, inv_b;
  logic [24:0]          alpha_p;
  logic [7:0]           alpha;
  logic [33:0]          usq;
  logic [16:0]          gq    [3];
  logic [7:0]           chan  [3];
  logic [7:0]           glow  [3];

  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_ext   = 8'(in_word_i.light_slot);
  assign wr_light   = in_acc && (in_word_i.cmd == CMD_WRITE_LIGHT) &&
                      (9'(in_word_i.light_slot) < 9'(MAX_LIGHTS));
  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign last       = (idx_q == LastIdx);

  // ---- configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_left_q  <= '0;
      view_top_q   <= '0;
      cell_size_q  <= 11'd16;
      min_bright_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VIEW_LEFT:      view_left_q  <= cfg_data_i[15:0];
        REG_VIEW_TOP:       view_top_q   <= cfg_data_i[15:0];
        REG_CELL_SIZE:      cell_size_q  <= cfg_data_i[10:0];
        REG_MIN_BRIGHTNESS: min_bright_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // ---- light table memory
  always_ff @(posedge clk_i) begin
    if (wr_light) begin
      mem[slot_ext[IdxW-1:0]] <= '{y: in_word_i.light_y, x: in_word_i.light_x,
                                  reach: in_word_i.light_radius,
                                  red: in_word_i.light_red,
                                  green: in_word_i.light_green,
                                  blue: in_word_i.light_blue};
    end
    if (state_q == ST_READ) begin
      rd_q <= mem[idx_q];
    end
  end

  // ---- arithmetic units
  plcs_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({d2_q[35:0], 24'b0}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_comb begin
    if (div_glow) begin
      div_num = DIV_NUM_W'(root);
      div_den = {3'b000, rd_q.reach, 13'b0};
    end else begin
      div_num = {1'b0, root, 2'b00} + DIV_NUM_W'(root);
      div_den = {({4'b0, rd_q.reach} << 3) + ({4'b0, rd_q.reach} << 2), 12'b0};
    end
  end

  plcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // ---- combinational datapath pieces
  always_comb begin
    vl2  = {{8{view_left_q[15]}}, view_left_q, 1'b0};
    vt2  = {{8{view_top_q[15]}}, view_top_q, 1'b0};
    pcx  = $signed({3'b000, 21'(col_q * cell_size_q), 1'b0});
    pcy  = $signed({3'b000, 21'(row_q * cell_size_q), 1'b0});
    cs_e = $signed({14'b0, cell_size_q});
    ddx  = $signed({{8{rd_q.x[15]}}, rd_q.x, 1'b0}) - cx2_q;
    ddy  = $signed({{8{rd_q.y[15]}}, rd_q.y, 1'b0}) - cy2_q;
    d2x25  = ({5'b0, d2_q} << 4) + ({5'b0, d2_q} << 3) + {5'b0, d2_q};
    r2x144 = ({22'b0, r2_q} << 7) + ({22'b0, r2_q} << 4);
    in_shadow = d2x25 < r2x144;
    cand  = ONE - quot;
    usq   = u_q * u_q;
    inv_b = ONE - bright_q;
    alpha_p = ({8'b0, inv_b} << 8) - {8'b0, inv_b};
    alpha = bright_q[16] ? 8'd0 : alpha_p[23:16];
    chan[0] = rd_q.red;
    chan[1] = rd_q.green;
    chan[2] = rd_q.blue;
    for (int c = 0; c < 3; c++) begin
      // sum / 130560 is (sum >> 9) / 255; below saturation sum >> 9 fits 16 bits
      gq[c]   = {1'b0, sum_q[c][24:9]} + 17'(sum_q[c][24:17]) + 17'd1;
      glow[c] = sat_q[c] ? 8'd255 : sq_q[c];
    end
  end

  // ---- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      en_q    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (wr_light) begin
        en_q[slot_ext[IdxW-1:0]] <= in_word_i.light_on;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    div_glow   = 1'b0;
    load_out   = 1'b0;
    adv        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_word_i.cmd == CMD_SHADE_CELL)) state_d = ST_CENTER;
      end
      ST_CENTER: begin
        idx_d   = '0;
        state_d = ST_READ;
      end
      ST_READ: begin
        if (en_q[idx_q]) state_d = ST_DIST;
        else adv = 1'b1;
      end
      ST_DIST:   state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_TEST;
      ST_TEST: begin
        if (in_shadow) begin
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end else begin
          adv = 1'b1;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          state_d   = ST_SHDIV;
        end
      end
      ST_SHDIV: begin
        if (div_done) begin
          if (glow_q) begin
            div_start = 1'b1;
            div_glow  = 1'b1;
            state_d   = ST_GLDIV;
          end else begin
            adv = 1'b1;
          end
        end
      end
      ST_GLDIV: begin
        if (div_done) state_d = ST_UMUL;
      end
      ST_UMUL:   state_d = ST_ACC;
      ST_ACC:    adv = 1'b1;
      ST_SATCHK: state_d = ST_DONE;
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (adv) begin
      if (last) begin
        state_d = ST_SATCHK;
      end else begin
        idx_d   = IdxW'(idx_q + 1'b1);
        state_d = ST_READ;
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= in_word_i.cell_col;
      row_q <= in_word_i.cell_row;
    end
    unique case (state_q)
      ST_CENTER: begin
        cx2_q    <= vl2 + pcx + cs_e;
        cy2_q    <= vt2 + pcy + cs_e;
        bright_q <= min_bright_q;
        for (int c = 0; c < 3; c++) sum_q[c] <= '0;
      end
      ST_DIST: begin
        dx_q <= ddx[24] ? 24'(-ddx) : ddx[23:0];
        dy_q <= ddy[24] ? 24'(-ddy) : ddy[23:0];
      end
      ST_SQUARE: begin
        d2_q <= 49'(dx_q * dx_q) + 49'(dy_q * dy_q);
        r2_q <= rd_q.reach * rd_q.reach;
      end
      ST_TEST: begin
        glow_q <= d2_q < {15'b0, r2_q, 2'b00};
      end
      ST_SHDIV: begin
        if (div_done && (cand > bright_q)) bright_q <= cand;
      end
      ST_GLDIV: begin
        if (div_done) u_q <= cand;
      end
      ST_UMUL: begin
        u2_q <= usq[32:16];
      end
      ST_ACC: begin
        for (int c = 0; c < 3; c++) begin
          sum_q[c] <= sum_q[c] + SumW'(chan[c] * u2_q);
        end
      end
      ST_SATCHK: begin
        for (int c = 0; c < 3; c++) begin
          sat_q[c] <= sum_q[c] >= SumW'(GLOW_SAT);
          sq_q[c]  <= gq[c][15:8];
        end
      end
      default: ;
    endcase
  end

  // ---- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_word_q <= '{out_col: col_q, out_row: row_q, shadow_alpha: alpha,
                      glow_red: glow[0], glow_green: glow[1], glow_blue: glow[2]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== hdl/plcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_checker
// Port-level checks of the point light cell shader, bound to the top level.
// ----------------------------------------------------------------------------
module plcs_checker
  import plcs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // a light write never produces a result word
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.cmd == CMD_WRITE_LIGHT)
    |=> !$rose(out_valid_o))
    else $error("result word after a light write");

  // a shade word keeps the engine busy
  a_shade_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.cmd == CMD_SHADE_CELL)
    |=> !in_ready_o)
    else $error("input ready right after a shade word");

endmodule

bind point_light_cell_shader_unit plcs_checker u_plcs_checker (.*);

// ===== bench/point_light_cell_shader_unit_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_light_cell_shader_unit_check
// Watches the input, output and register channels of the point light cell
// shader, keeps its own light table and register copy, predicts each shaded
// cell word and compares every output word field by field in order.
// ----------------------------------------------------------------------------
module point_light_cell_shader_unit_check
  import plcs_pkg::*;
#(
  parameter int MAX_LIGHTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    error_count_o,
  output int                    pending_o,
  output int                    shaded_o,
  output int                    lights_written_o
);

  localparam bit [63:0] UNIT = 64'd1 << FRAC_BITS;

  // register copy
  longint    left_px;
  longint    top_px;
  bit [63:0] cell_px;
  bit [63:0] floor_bright;

  // light table copy
  light_t    lamp     [MAX_LIGHTS];
  bit        lamp_lit [MAX_LIGHTS];

  out_word_t shade_queue[$];
  int        errors;

  function automatic bit [63:0] floor_root(bit [63:0] n);
    bit [63:0] acc = 0;
    bit [63:0] pick = 64'd1 << 62;
    while (pick > n) pick >>= 2;
    while (pick != 0) begin
      if (n >= acc + pick) begin
        n   -= acc + pick;
        acc  = (acc >> 1) + pick;
      end else begin
        acc >>= 1;
      end
      pick >>= 2;
    end
    return acc;
  endfunction

  function automatic out_word_t shade_cell(logic [9:0] col, logic [9:0] row);
    out_word_t res;
    longint    cx2, cy2;
    bit [63:0] bright, alpha, dx, dy, d2, r, h, t, u, u2, v;
    bit [63:0] sum [3];
    cx2 = 2 * left_px + 2 * longint'(64'(col) * cell_px) + longint'(cell_px);
    cy2 = 2 * top_px + 2 * longint'(64'(row) * cell_px) + longint'(cell_px);
    bright = floor_bright;
    sum = '{0, 0, 0};
    for (int i = 0; i < MAX_LIGHTS; i++) begin
      if (lamp_lit[i]) begin
        dx = 2 * longint'(lamp[i].x) - cx2;
        if (dx[63]) dx = -dx;
        dy = 2 * longint'(lamp[i].y) - cy2;
        if (dy[63]) dy = -dy;
        d2 = dx * dx + dy * dy;
        r  = 64'(lamp[i].reach);
        // shadow reach is 1.2 r, compared in squares
        if (25 * d2 < 144 * r * r) begin
          h = floor_root(d2 << (2 * DIST_FRAC));
          t = ((5 * h) << FRAC_BITS) / ((12 * r) << DIST_FRAC);
          if (UNIT - t > bright) bright = UNIT - t;
        end
        if (d2 < 4 * r * r) begin
          h = floor_root(d2 << (2 * DIST_FRAC));
          t = (h << FRAC_BITS) / (r << (DIST_FRAC + 1));
          u = UNIT - t;
          u2 = (u * u) >> FRAC_BITS;
          sum[0] += 64'(lamp[i].red) * u2;
          sum[1] += 64'(lamp[i].green) * u2;
          sum[2] += 64'(lamp[i].blue) * u2;
        end
      end
    end
    if (bright >= UNIT) alpha = 0;
    else alpha = (255 * (UNIT - bright)) >> FRAC_BITS;
    if (alpha > 255) alpha = 255;
    for (int c = 0; c < 3; c++) begin
      v = (sum[c] * 128) / (255 * UNIT);
      sum[c] = (v > 255) ? 64'd255 : v;
    end
    res.out_col      = col;
    res.out_row      = row;
    res.shadow_alpha = alpha[7:0];
    res.glow_red     = sum[0][7:0];
    res.glow_green   = sum[1][7:0];
    res.glow_blue    = sum[2][7:0];
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      left_px      = 0;
      top_px       = 0;
      cell_px      = 16;
      floor_bright = 0;
      errors       = 0;
      for (int i = 0; i < MAX_LIGHTS; i++) lamp_lit[i] = 1'b0;
      shade_queue.delete();
      shaded_o         <= 0;
      lights_written_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_VIEW_LEFT:      left_px      = longint'($signed(cfg_data_i[15:0]));
          REG_VIEW_TOP:       top_px       = longint'($signed(cfg_data_i[15:0]));
          REG_CELL_SIZE:      cell_px      = 64'(cfg_data_i[10:0]);
          REG_MIN_BRIGHTNESS: floor_bright = 64'(cfg_data_i[16:0]);
          default: ;
        endcase
      end
      // drain before fill: a word taken this edge cannot answer this edge
      if (out_valid_i && out_ready_i) begin
        if (shade_queue.size() == 0) begin
          $display("%0t: output word with nothing expected", $realtime);
          errors++;
        end else begin
          want = shade_queue.pop_front();
          if (out_word_i.out_col != want.out_col)
            report("out_col", out_word_i.out_col, want.out_col);
          if (out_word_i.out_row != want.out_row)
            report("out_row", out_word_i.out_row, want.out_row);
          if (out_word_i.shadow_alpha != want.shadow_alpha)
            report("shadow_alpha", out_word_i.shadow_alpha, want.shadow_alpha);
          if (out_word_i.glow_red != want.glow_red)
            report("glow_red", out_word_i.glow_red, want.glow_red);
          if (out_word_i.glow_green != want.glow_green)
            report("glow_green", out_word_i.glow_green, want.glow_green);
          if (out_word_i.glow_blue != want.glow_blue)
            report("glow_blue", out_word_i.glow_blue, want.glow_blue);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_word_i.cmd == CMD_SHADE_CELL) begin
          shade_queue = {shade_queue, shade_cell(in_word_i.cell_col, in_word_i.cell_row)};
          shaded_o <= shaded_o + 1;
        end else if (int'(in_word_i.light_slot) < MAX_LIGHTS) begin
          lamp[in_word_i.light_slot] = '{y: in_word_i.light_y, x: in_word_i.light_x,
                                         reach: in_word_i.light_radius,
                                         red: in_word_i.light_red,
                                         green: in_word_i.light_green,
                                         blue: in_word_i.light_blue};
          lamp_lit[in_word_i.light_slot] = in_word_i.light_on;
          lights_written_o <= lights_written_o + 1;
        end
      end
    end
    pending_o     <= shade_queue.size();
    error_count_o <= errors;
  end

endmodule

// ===== bench/point_light_cell_shader_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_light_cell_shader_unit_test
// Drives light writes and cell shade words through the shader under random
// stalls on both sides and several register settings; the checker beside the
// block predicts every output word and counts mismatches.
// ----------------------------------------------------------------------------
module point_light_cell_shader_unit_test;
  import plcs_pkg::*;

  localparam int N_PHASES     = 8;
  localparam int PHASE_WORDS  = 136;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_word_t              in_word_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_word_t             out_word_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int error_count, pending, shaded, lights_written;
  int idle_cnt = 0;
  bit tx_gaps, rx_gaps, hold_req;
  int cur_left, cur_cell;

  point_light_cell_shader_unit i_dut (.*);

  point_light_cell_shader_unit_check i_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_word_i(out_word_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .error_count_o(error_count), .pending_o(pending),
    .shaded_o(shaded), .lights_written_o(lights_written)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int gap;
    bit hold_done;
    gap = 0;
    hold_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        gap = 400;
      end
      if (gap > 0) begin
        out_ready_i = 1'b0;
        gap--;
      end else begin
        out_ready_i = 1'b1;
        if (rx_gaps && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
      end
    end
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("point_light_cell_shader_unit_test: errors");
      $finish;
    end
  end

  function automatic in_word_t light_word(int slot, int x, int y, int r, int red,
                                          int green, int blue, bit on);
    in_word_t w;
    w = in_word_t'($urandom());
    w.cmd = CMD_WRITE_LIGHT;
    w.light_slot = 4'(slot);
    w.light_x = 16'(x);
    w.light_y = 16'(y);
    w.light_radius = 16'(r);
    w.light_red = 8'(red);
    w.light_green = 8'(green);
    w.light_blue = 8'(blue);
    w.light_on = on;
    return w;
  endfunction

  function automatic in_word_t cell_word(int col, int row);
    in_word_t w;
    w = in_word_t'({$urandom(), $urandom(), $urandom()});
    w.cmd = CMD_SHADE_CELL;
    w.cell_col = 10'(col);
    w.cell_row = 10'(row);
    return w;
  endfunction

  // mostly lights and cells near the view origin, now and then anything
  function automatic in_word_t random_word();
    in_word_t w;
    int span;
    span = 8 * cur_cell + cur_cell + 2;
    if ($urandom_range(0, 9) < 3) begin
      if ($urandom_range(0, 4) == 0)
        w = in_word_t'({$urandom(), $urandom(), $urandom()});
      else
        w = light_word($urandom_range(0, 15), cur_left + $urandom_range(0, span),
                       cur_left + $urandom_range(0, span),
                       $urandom_range(1, 4 * cur_cell + 40), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 7) != 0);
      w.cmd = CMD_WRITE_LIGHT;
    end else if ($urandom_range(0, 7) == 0) begin
      w = cell_word($urandom_range(0, 1023), $urandom_range(0, 1023));
    end else begin
      w = cell_word($urandom_range(0, 7), $urandom_range(0, 7));
    end
    return w;
  endfunction

  task automatic send(in_word_t w);
    @(negedge clk_i);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // hold until every shade word has answered and the engine is at rest
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    int left_v, top_v, cell_v, floor_v;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    hold_req    = 1'b0;
    cur_left    = 0;
    cur_cell    = 16;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, zero radius, a light switched off
    send(cell_word(0, 0));
    send(light_word(0, 8, 8, 40, 255, 255, 255, 1'b1));
    send(cell_word(0, 0));
    send(light_word(15, -32768, 32767, 65535, 255, 0, 128, 1'b1));
    send(light_word(3, 24, 8, 0, 255, 255, 255, 1'b1));
    send(light_word(4, 8, 24, 100, 255, 255, 255, 1'b0));
    send(light_word(1, 30, 20, 1, 0, 255, 0, 1'b1));
    send(light_word(2, 32767, -32768, 65535, 0, 0, 255, 1'b1));
    send(cell_word(1023, 1023));
    send(cell_word(1, 1));
    send(cell_word(0, 1023));
    send(cell_word(1023, 0));
    send(light_word(5, 8, 8, 65535, 255, 255, 255, 1'b1));
    send(light_word(6, 9, 9, 65535, 255, 255, 255, 1'b1));
    send(cell_word(0, 0));
    send(cell_word(2, 3));
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin left_v = -32768; top_v = -32768; cell_v = 1;    floor_v = 0;      end
        1: begin left_v = 32767;  top_v = 32767;  cell_v = 2047; floor_v = 131071; end
        2: begin left_v = 0;      top_v = 0;      cell_v = 0;    floor_v = 65536;  end
        3: begin left_v = -100;   top_v = -100;   cell_v = 16;   floor_v = 20000;  end
        5: begin
          left_v = $urandom_range(0, 65535) - 32768; top_v = left_v;
          cell_v = 1024; floor_v = $urandom_range(0, 65536);
        end
        default: begin
          left_v = $urandom_range(0, 2000) - 1000; top_v = left_v;
          cell_v = $urandom_range(1, 64); floor_v = $urandom_range(0, 65536);
        end
      endcase
      write_reg(REG_VIEW_LEFT, left_v);
      write_reg(REG_VIEW_TOP, top_v);
      write_reg(REG_CELL_SIZE, cell_v);
      write_reg(REG_MIN_BRIGHTNESS, floor_v);
      if (p == 2) write_reg(REG_NONE, $urandom());
      cur_left = left_v;
      cur_cell = (cell_v == 0) ? 1 : cell_v;
      if (p == N_PHASES - 1) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 3 && k == 10) hold_req = 1'b1;
        send(random_word());
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d shaded cells and %0d light writes under %0d register settings",
             shaded, lights_written, N_PHASES + 1);
    if (error_count == 0)
      $display("point_light_cell_shader_unit_test: clean");
    else
      $display("point_light_cell_shader_unit_test: errors");
    $finish;
  end

endmodule
